@@ rtl/brwm_pkg.sv @@
// Shared types and constants for the banked ROM window mapper.
package brwm_pkg;

	// Address map and fixed sizes.
	localparam int unsigned MAP_SPAN     = 4194304;
	localparam int unsigned BOOT_AREA    = 8192;
	localparam int unsigned WRITE_WINDOW = 65536;
	localparam int unsigned BOOT_W       = $clog2(BOOT_AREA);

	localparam int unsigned ADDR_W   = 24;
	localparam int unsigned OFFS_W   = 22;
	localparam int unsigned ROM_W    = 23;
	localparam int unsigned UNIT_W   = 5;
	localparam int unsigned UNIT_SHIFT = 17;

	localparam logic [ADDR_W-1:0] REG_BASE    = 24'h400000;
	localparam logic [ADDR_W-1:0] REG_BANK_HI = 24'h400000;
	localparam logic [ADDR_W-1:0] REG_SIZE    = 24'h402000;
	localparam logic [ADDR_W-1:0] REG_BANK_LO = 24'h404000;

	localparam logic [ROM_W-1:0] ROM_SIZE_RESET = 23'd4194304;

	// Operation codes of an input word.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Mapper state, kept as one record in the state memory.
	typedef struct packed {
		logic [UNIT_W-1:0] bank_bits;
		logic              bank_known;
		logic [UNIT_W-1:0] size_units;
		logic              size_known;
		logic [UNIT_W-1:0] active_bank_units;
		logic [UNIT_W-1:0] active_size_units;
		logic              boot_mode;
	} map_state_t;

	localparam map_state_t STATE_RESET = '{
		bank_bits:         '0,
		bank_known:        1'b0,
		size_units:        '0,
		size_known:        1'b0,
		active_bank_units: '0,
		active_size_units: '0,
		boot_mode:         1'b1
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_OUT
	} ctrl_state_t;

endpackage

@@ rtl/banked_rom_window_mapper_unit.sv @@
// Top level of the banked ROM window mapper.
// The mapper takes one CPU bus word at a time, a byte write or a read, and gives one result
// word for each. Writes to 0x400000, 0x402000 and 0x404000 set the high bank bits, the window
// size in 128 KB units and the low bank bits; other writes in the register window are flagged.
// Until a complete setting has been accepted every read below 4 MB maps into the last 8 KB of
// the ROM, and afterwards such a read maps to bank plus address modulo window size. The mapper
// state lives in a one-entry synchronous memory that is read when a word is taken and written
// back when a write's result is registered, so words are handled one after another. A read that
// maps through an active window passes through the five-step remainder unit before its result
// is registered; every other word goes from the state read straight to the output register. A
// result waiting in the output register does not hold off acceptance of the next word.
module banked_rom_window_mapper_unit
	import brwm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ROM_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic [ADDR_W-1:0] address,
	input  logic [7:0]        data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              mapped,
	output logic [OFFS_W-1:0] rom_offset,
	output logic              unexpected_write,
	output logic              map_rejected
);

	ctrl_state_t       state_q;
	ctrl_state_t       state_next;
	logic [ROM_W-1:0]  rom_size_q;
	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        data_q;
	map_state_t        state_mem [1];
	map_state_t        state_rd_q;
	logic              state_valid_q;
	map_state_t        cur;
	map_state_t        upd;
	logic              accept;
	logic              rem_start;
	logic              rem_done;
	logic [UNIT_W-1:0] rem_val;
	logic              load_out;
	logic              slot_free;
	logic              needs_div;
	logic              in_span;
	logic              in_window;
	logic              reg_hit;
	logic              changed;
	logic              check;
	logic [ROM_W:0]    map_end;
	logic              res_mapped;
	logic [OFFS_W-1:0] res_offset;
	logic              res_unexpected;
	logic              res_rejected;
	logic [ROM_W-1:0]  boot_sum;
	logic [OFFS_W-1:0] win_offset;
	logic              out_valid_q;
	logic              mapped_q;
	logic [OFFS_W-1:0] rom_offset_q;
	logic              unexpected_q;
	logic              rejected_q;

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// An entry never written since reset reads as the reset state.
	assign cur = state_valid_q ? state_rd_q : STATE_RESET;

	assign in_span   = addr_q < ADDR_W'(MAP_SPAN);
	assign in_window = (addr_q >= REG_BASE) && ((addr_q - REG_BASE) < ADDR_W'(WRITE_WINDOW));
	assign needs_div = (op_q == OP_READ) && in_span && !cur.boot_mode
		&& (cur.active_size_units != '0);

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				state_next = needs_div ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (rem_done) begin
					state_next = ST_OUT;
				end
			end
			ST_OUT: begin
				if (slot_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_stall  = 1'b1;
		rem_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall  = 1'b0;
			ST_READ: rem_start = needs_div;
			ST_DIV:  ;
			ST_OUT:  load_out  = slot_free;
			default: ;
		endcase
	end

	brwm_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (addr_q[UNIT_SHIFT+UNIT_W-1:UNIT_SHIFT]),
		.divisor   (cur.active_size_units),
		.done      (rem_done),
		.remainder (rem_val)
	);

	// Register writes and the check of a new setting.
	always_comb begin
		upd     = cur;
		reg_hit = 1'b1;
		priority if (addr_q == REG_BANK_HI) begin
			upd.bank_bits[4:3] = data_q[2:1];
			upd.bank_known     = 1'b1;
		end else if (addr_q == REG_SIZE) begin
			upd.size_units = data_q[UNIT_W-1:0];
			upd.size_known = 1'b1;
		end else if (addr_q == REG_BANK_LO) begin
			upd.bank_bits[2:0] = data_q[2:0];
			upd.bank_known     = 1'b1;
		end else begin
			reg_hit = 1'b0;
		end

		changed = (upd.bank_bits != cur.bank_bits) || (upd.size_units != cur.size_units)
			|| (upd.bank_known != cur.bank_known) || (upd.size_known != cur.size_known);
		check   = in_window && reg_hit && upd.bank_known && upd.size_known && changed;
		map_end = {2'b00, upd.bank_bits, UNIT_SHIFT'(0)} + {2'b00, upd.size_units, UNIT_SHIFT'(0)};

		res_unexpected = in_window && !reg_hit;
		res_rejected   = 1'b0;
		if (check) begin
			if ((upd.size_units == '0) || (map_end > {1'b0, rom_size_q})) begin
				res_rejected = 1'b1;
			end else begin
				upd.active_bank_units = upd.bank_bits;
				upd.active_size_units = upd.size_units;
				upd.boot_mode         = 1'b0;
			end
		end
		if (!in_window) begin
			upd = cur;
		end
	end

	// Read offsets. Both wrap modulo the 22-bit offset range.
	always_comb begin
		boot_sum   = rom_size_q - ROM_W'(BOOT_AREA) + ROM_W'(addr_q[BOOT_W-1:0]);
		win_offset = {cur.active_bank_units, UNIT_SHIFT'(0)}
			+ {rem_val, addr_q[UNIT_SHIFT-1:0]};
		res_mapped = (op_q == OP_READ) && in_span;
		if (!res_mapped) begin
			res_offset = '0;
		end else if (cur.boot_mode || (cur.active_size_units == '0)) begin
			res_offset = boot_sum[OFFS_W-1:0];
		end else begin
			res_offset = win_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rom_size_q    <= ROM_SIZE_RESET;
			state_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_we) begin
				rom_size_q <= cfg_wdata;
			end
			if (load_out && (op_q == OP_WRITE)) begin
				state_valid_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// State memory: read when a word is taken, written back with the result of a write.
	always_ff @(posedge clk) begin
		if (load_out && (op_q == OP_WRITE)) begin
			state_mem[0] <= upd;
		end
		if (accept) begin
			state_rd_q <= state_mem[0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			addr_q <= address;
			data_q <= data;
		end
		if (load_out) begin
			mapped_q     <= res_mapped;
			rom_offset_q <= res_offset;
			unexpected_q <= (op_q == OP_WRITE) && res_unexpected;
			rejected_q   <= (op_q == OP_WRITE) && res_rejected;
		end
	end

	assign out_valid        = out_valid_q;
	assign mapped           = mapped_q;
	assign rom_offset       = rom_offset_q;
	assign unexpected_write = unexpected_q;
	assign map_rejected     = rejected_q;

endmodule

@@ rtl/brwm_rem.sv @@
// Restoring remainder unit: one quotient bit per cycle on 5-bit operands.
module brwm_rem
	import brwm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [UNIT_W-1:0] dividend,
	input  logic [UNIT_W-1:0] divisor,
	output logic              done,
	output logic [UNIT_W-1:0] remainder
);

	localparam int unsigned CNT_W = $clog2(UNIT_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(UNIT_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [UNIT_W-1:0] rem_q;
	logic [UNIT_W-1:0] num_q;
	logic [UNIT_W-1:0] div_q;
	logic [UNIT_W:0]   trial;
	logic [UNIT_W:0]   diff;
	logic [UNIT_W-1:0] rem_next;

	// Shift in the next dividend bit and subtract the divisor where it fits.
	always_comb begin
		trial = {rem_q, num_q[UNIT_W-1]};
		diff  = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q}) begin
			rem_next = diff[UNIT_W-1:0];
		end else begin
			rem_next = trial[UNIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= {num_q[UNIT_W-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the banked ROM window mapper unit.
`timescale 1ns / 100ps

module tb;
	import brwm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_WORDS = 125;
	localparam int unsigned NUM_PHASES  = 6;

	typedef struct packed {
		logic              mapped;
		logic [OFFS_W-1:0] rom_offset;
		logic              unexpected_write;
		logic              map_rejected;
	} map_result_t;

	typedef enum logic {ROW_ACCESS, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic              op;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        dat;
		logic              typed;
		map_result_t       want;
		logic [ROM_W-1:0]  cfg_val;
	} dir_row_t;

	localparam map_result_t QUIET      = '0;
	localparam map_result_t STRAY      = '{1'b0, 22'h0, 1'b1, 1'b0};
	localparam map_result_t REFUSED    = '{1'b0, 22'h0, 1'b0, 1'b1};
	localparam int unsigned DIR_ROWS   = 28;

	// Rows with typed results are read straight off the boot area and register map.
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{ROW_ACCESS, OP_READ,  24'h000000, 8'h00, 1'b1, '{1'b1, 22'h3FE000, 1'b0, 1'b0}, 23'd0},
		'{ROW_ACCESS, OP_READ,  24'h3FFFFF, 8'hFF, 1'b1, '{1'b1, 22'h3FFFFF, 1'b0, 1'b0}, 23'd0},
		'{ROW_ACCESS, OP_READ,  24'h400000, 8'hFF, 1'b1, QUIET, 23'd0},
		'{ROW_ACCESS, OP_READ,  24'hFFFFFF, 8'h00, 1'b1, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, 24'h000000, 8'hFF, 1'b1, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, 24'hFFFFFF, 8'hFF, 1'b1, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, 24'h400001, 8'hFF, 1'b1, STRAY, 23'd0},
		'{ROW_ACCESS, OP_WRITE, 24'h40FFFF, 8'h00, 1'b1, STRAY, 23'd0},
		'{ROW_ACCESS, OP_WRITE, 24'h410000, 8'hFF, 1'b1, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, REG_SIZE,    8'h00, 1'b1, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, REG_BANK_HI, 8'h00, 1'b1, REFUSED, 23'd0},
		'{ROW_ACCESS, OP_READ,  24'h123456, 8'h00, 1'b1, '{1'b1, 22'h3FF456, 1'b0, 1'b0}, 23'd0},
		'{ROW_CFG,    OP_READ,  24'h000000, 8'h00, 1'b0, QUIET, 23'd4096},
		'{ROW_ACCESS, OP_READ,  24'h001234, 8'h00, 1'b1, '{1'b1, 22'h000234, 1'b0, 1'b0}, 23'd0},
		'{ROW_ACCESS, OP_READ,  24'h000000, 8'h00, 1'b1, '{1'b1, 22'h3FF000, 1'b0, 1'b0}, 23'd0},
		'{ROW_CFG,    OP_READ,  24'h000000, 8'h00, 1'b0, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, REG_SIZE,    8'h01, 1'b1, REFUSED, 23'd0},
		'{ROW_ACCESS, OP_READ,  24'h001FFF, 8'h00, 1'b1, '{1'b1, 22'h3FFFFF, 1'b0, 1'b0}, 23'd0},
		'{ROW_CFG,    OP_READ,  24'h000000, 8'h00, 1'b0, QUIET, 23'd4194304},
		'{ROW_ACCESS, OP_WRITE, REG_SIZE,    8'hFF, 1'b0, QUIET, 23'd0},
		'{ROW_ACCESS, OP_READ,  24'h3FFFFF, 8'h00, 1'b0, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, REG_BANK_LO, 8'hFF, 1'b0, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, REG_BANK_LO, 8'h07, 1'b0, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, REG_SIZE,    8'hE1, 1'b0, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, REG_BANK_HI, 8'hFF, 1'b0, QUIET, 23'd0},
		'{ROW_ACCESS, OP_READ,  24'h3FFFFF, 8'h00, 1'b0, QUIET, 23'd0},
		'{ROW_ACCESS, OP_WRITE, REG_SIZE,    8'h00, 1'b0, QUIET, 23'd0},
		'{ROW_ACCESS, OP_READ,  24'h000000, 8'h00, 1'b0, QUIET, 23'd0}
	};

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [ROM_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              opcode = OP_READ;
	logic [ADDR_W-1:0] address = '0;
	logic [7:0]        data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              mapped;
	logic [OFFS_W-1:0] rom_offset;
	logic              unexpected_write;
	logic              map_rejected;

	// Mirror of the mapper state and its one register.
	logic [ROM_W-1:0]  mir_rom_size;
	logic [UNIT_W-1:0] mir_bank_bits;
	logic              mir_bank_known;
	logic [UNIT_W-1:0] mir_size_units;
	logic              mir_size_known;
	logic [OFFS_W-1:0] mir_active_bank;
	logic [UNIT_W-1:0] mir_active_size;
	logic              mir_boot_mode;

	map_result_t pending_results[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	bit          calm = 1'b0;
	bit          hold_rx = 1'b0;

	banked_rom_window_mapper_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.address          (address),
		.data             (data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.mapped           (mapped),
		.rom_offset       (rom_offset),
		.unexpected_write (unexpected_write),
		.map_rejected     (map_rejected)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void reset_mirror();
		mir_rom_size    = ROM_SIZE_RESET;
		mir_bank_bits   = '0;
		mir_bank_known  = 1'b0;
		mir_size_units  = '0;
		mir_size_known  = 1'b0;
		mir_active_bank = '0;
		mir_active_size = '0;
		mir_boot_mode   = 1'b1;
	endfunction

	// Works out the result of one bus word and moves the mirrored state on.
	function automatic map_result_t map_access(input logic op, input logic [ADDR_W-1:0] a,
			input logic [7:0] d);
		map_result_t       res;
		logic [31:0]       sum;
		logic [31:0]       span;
		logic [31:0]       bank_b;
		logic [31:0]       size_b;
		logic [UNIT_W-1:0] old_bank;
		logic [UNIT_W-1:0] old_size;
		logic              old_bk;
		logic              old_sk;
		logic              hit;
		res = '0;
		if (op == OP_READ) begin
			if (32'(a) < MAP_SPAN) begin
				res.mapped = 1'b1;
				if (mir_boot_mode || mir_active_size == '0) begin
					sum = 32'(mir_rom_size) - BOOT_AREA + (32'(a) % BOOT_AREA);
				end else begin
					span = 32'(mir_active_size) << UNIT_SHIFT;
					sum  = 32'(mir_active_bank) + (32'(a) % span);
				end
				res.rom_offset = sum[OFFS_W-1:0];
			end
		end else if (a >= REG_BASE && 32'(a - REG_BASE) < WRITE_WINDOW) begin
			old_bank = mir_bank_bits;
			old_size = mir_size_units;
			old_bk   = mir_bank_known;
			old_sk   = mir_size_known;
			hit      = 1'b1;
			if (a == REG_BANK_HI) begin
				mir_bank_bits  = {d[2:1], mir_bank_bits[2:0]};
				mir_bank_known = 1'b1;
			end else if (a == REG_SIZE) begin
				mir_size_units = d[4:0];
				mir_size_known = 1'b1;
			end else if (a == REG_BANK_LO) begin
				mir_bank_bits  = {mir_bank_bits[4:3], d[2:0]};
				mir_bank_known = 1'b1;
			end else begin
				res.unexpected_write = 1'b1;
				hit = 1'b0;
			end
			if (hit && mir_bank_known && mir_size_known &&
					(mir_bank_bits != old_bank || mir_size_units != old_size ||
					 mir_bank_known != old_bk || mir_size_known != old_sk)) begin
				bank_b = 32'(mir_bank_bits) << UNIT_SHIFT;
				size_b = 32'(mir_size_units) << UNIT_SHIFT;
				if (mir_size_units == '0 || bank_b + size_b > 32'(mir_rom_size)) begin
					res.map_rejected = 1'b1;
				end else begin
					mir_active_bank = bank_b[OFFS_W-1:0];
					mir_active_size = mir_size_units;
					mir_boot_mode   = 1'b0;
				end
			end
		end
		return res;
	endfunction

	task automatic offer_word(input logic op, input logic [ADDR_W-1:0] a, input logic [7:0] d,
			input logic typed, input map_result_t want);
		int unsigned gap;
		map_result_t pred;
		gap = (calm || hold_rx) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		address  <= a;
		data     <= d;
		do @(posedge clk); while (in_stall);
		pred = map_access(op, a, d);
		pending_results.push_back(typed ? want : pred);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// The register is only written once the mapper has nothing in flight.
	task automatic write_rom_size(input logic [ROM_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		mir_rom_size = value;
	endtask

	task automatic random_word();
		int unsigned       pick;
		logic              op;
		logic [ADDR_W-1:0] a;
		logic [7:0]        d;
		pick = $urandom_range(0, 99);
		d    = 8'($urandom);
		if (pick < 50) begin
			op = OP_READ;
			if ($urandom_range(0, 9) == 0) begin
				a = 24'($urandom_range(MAP_SPAN, 24'hFFFFFF));
			end else begin
				a = 24'($urandom_range(0, MAP_SPAN - 1));
			end
		end else if (pick < 85) begin
			op = OP_WRITE;
			case ($urandom_range(0, 2))
				0: a = REG_BANK_HI;
				1: a = REG_SIZE;
				default: a = REG_BANK_LO;
			endcase
			// Small windows most of the time, so that settings are often accepted.
			if (a == REG_SIZE && $urandom_range(0, 1) == 0) begin
				d[4:0] = 5'($urandom_range(1, 4));
			end
		end else if (pick < 93) begin
			op = OP_WRITE;
			a  = REG_BASE + 24'($urandom_range(0, WRITE_WINDOW - 1));
		end else begin
			op = 1'($urandom);
			a  = 24'($urandom);
		end
		offer_word(op, a, d, 1'b0, QUIET);
	endtask

	function automatic logic [ROM_W-1:0] phase_rom_size(input int unsigned phase);
		case (phase)
			0: return ROM_SIZE_RESET;
			1: return '0;
			2: return ROM_W'($urandom_range(0, 32) << UNIT_SHIFT);
			3: return ROM_W'($urandom_range(0, MAP_SPAN));
			4: return ROM_W'(1 << UNIT_SHIFT);
			default: return ROM_W'($urandom_range(16, 32) << UNIT_SHIFT);
		endcase
	endfunction

	initial begin : stimulus
		int unsigned row;
		int unsigned phase;
		int unsigned n;
		reset_mirror();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIR_ROWS; row++) begin
			if (DIR_TAB[row].kind == ROW_CFG) begin
				write_rom_size(DIR_TAB[row].cfg_val);
			end else begin
				offer_word(DIR_TAB[row].op, DIR_TAB[row].addr, DIR_TAB[row].dat,
					DIR_TAB[row].typed, DIR_TAB[row].want);
			end
		end

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			write_rom_size(phase_rom_size(phase));
			if (phase == 0) hold_rx = 1'b1;
			for (n = 0; n < PHASE_WORDS; n++) begin
				calm = ((n % 60) < 15);
				random_word();
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("banked_rom_window_mapper_unit test passed");
		end else begin
			$display("banked_rom_window_mapper_unit test failed");
		end
		$finish;
	end

	// Result side: a random hold-off per word, and one long hold to back the mapper up.
	initial begin : receiver
		int unsigned n;
		forever begin
			if (hold_rx) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
				out_stall <= 1'b0;
			end else begin
				n = calm ? 0 : $urandom_range(0, 9);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		map_result_t want;
		map_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{mapped, rom_offset, unexpected_write, map_rejected};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result word: mapped %0b offset %h stray %0b refused %0b",
						got.mapped, got.rom_offset, got.unexpected_write, got.map_rejected);
				end
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: mapped %0b/%0b offset %h/%h stray %0b/%0b refused %0b/%0b",
							want.mapped, got.mapped, want.rom_offset, got.rom_offset,
							want.unexpected_write, got.unexpected_write,
							want.map_rejected, got.map_rejected);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("banked_rom_window_mapper_unit test failed");
			$finish;
		end
	end

endmodule
